FILE: src/hpdpg_pkg.sv
// Shared types and constants for the hot-plug-detect pulse pattern generator.
// No dependencies; used by the top level, the checker and the testbench.
package hpdpg_pkg;

    // Item kinds carried in the slave-side tuser field
    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_PLUG     = 3'd1,
        MODE_UNPLUG   = 3'd2,
        MODE_LOAD_SEG = 3'd3,
        MODE_START_RP = 3'd4,
        MODE_START_MX = 3'd5
    } mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LOW_WIDTH  = 3'd0,
        CFG_HIGH_WIDTH = 3'd1,
        CFG_REPEAT_CNT = 3'd2,
        CFG_END_HIGH   = 3'd3,
        CFG_SEG_COUNT  = 3'd4
    } cfg_index_t;

    localparam int FIELD_WIDTH = 24;  // width of all width fields and registers
    localparam int REPEAT_BITS = 16;
    localparam int SEGCNT_BITS = 6;
    localparam int SEGIDX_BITS = 5;
    localparam int STEP_BITS   = 17;  // phase number, up to twice the repeat count
    localparam int CFG_IDX_BITS = 3;

endpackage

FILE: src/hpdpg_seg_mem.sv
// Segment width store: one write port, one registered read port.
// Forwards a write made at the previous edge so a read never returns stale data.
// Depends on nothing but its parameters.
module hpdpg_seg_mem #(
    parameter int DEPTH = 32,
    parameter int DW    = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] mem_q_reg;
    logic [AW-1:0] raddr_reg;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [DW-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg    <= mem[raddr];
        raddr_reg    <= raddr;
        fwd_addr_reg <= waddr;
        fwd_data_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= we;
        end
    end

    // read at the same edge as a write sees old contents; take the written word
    assign rdata = (fwd_valid_reg && (fwd_addr_reg == raddr_reg)) ? fwd_data_reg : mem_q_reg;

endmodule

FILE: src/hpd_pulse_pattern_generator.sv
// Top level of the hot-plug-detect pulse pattern generator.
// Depends on hpdpg_pkg and hpdpg_seg_mem.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tuser/s_tdata) takes one item per
//   transaction: s_tuser carries the item kind (tick, plug, unplug, load
//   segment, start repeat, start mixed), s_tdata the segment slot and width.
//   Master stream (m_tvalid/m_tready/m_tdata) returns exactly one result per
//   item: line level, busy flag and error flag.
//   The config port (cfg_we/cfg_index/cfg_wdata) writes one register per
//   cycle with cfg_we high; write it only while no sequence runs.
//   The result is registered and shows in the cycle after the input transaction.
//   Throughput: one item per cycle while results are taken; all state updates
//   in the cycle of acceptance, and the segment memory read for the next phase
//   is issued ahead from the next phase number, so a phase change never waits.
//   Reset clears the line low and idle and loads register defaults; segment
//   slots hold no defined value until loaded.
//   When m_tready is low with a result held, s_tready drops and all state
//   holds until the result is taken.
module hpd_pulse_pattern_generator #(
    parameter int MAX_SEGMENTS = 32,
    parameter int WIDTH_BITS   = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tuser,   // [2:0] mode
    input  logic [31:0] s_tdata,   // [4:0] seg_index, [28:5] seg_width
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] hpd_level, [1] busy_res, [2] error
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int SW = (WIDTH_BITS < hpdpg_pkg::FIELD_WIDTH) ?
                        WIDTH_BITS : hpdpg_pkg::FIELD_WIDTH;
    localparam int ST = hpdpg_pkg::STEP_BITS;
    localparam logic [8:0]    MAX_9  = 9'(MAX_SEGMENTS);
    localparam logic [ST-1:0] MAX_ST = ST'(MAX_SEGMENTS);

    // configuration registers
    logic [hpdpg_pkg::FIELD_WIDTH-1:0] low_width_reg;
    logic [hpdpg_pkg::FIELD_WIDTH-1:0] high_width_reg;
    logic [hpdpg_pkg::REPEAT_BITS-1:0] repeat_count_reg;
    logic                              end_high_reg;
    logic [hpdpg_pkg::SEGCNT_BITS-1:0] segment_count_reg;

    // sequence state
    logic          line_level_reg, line_level_next;
    logic          running_reg, running_next;
    logic          mixed_mode_reg, mixed_mode_next;
    logic [SW-1:0] ticks_left_reg, ticks_left_next;
    logic [ST-1:0] step_reg, step_next;

    // output register
    logic m_valid_reg, m_valid_next;
    logic level_out_reg, busy_out_reg, error_out_reg;
    logic err;

    // input fields
    hpdpg_pkg::mode_t                  mode;
    logic [hpdpg_pkg::SEGIDX_BITS-1:0] seg_index;
    logic [hpdpg_pkg::FIELD_WIDTH-1:0] seg_width;
    logic                              accept;

    // segment memory
    logic          seg_we;
    logic [AW-1:0] seg_waddr;
    logic [AW-1:0] seg_raddr;
    logic [SW-1:0] seg_rdata;
    logic [8:0]    idx_wide;
    logic [ST-1:0] raddr_step;

    // derived values
    logic [SW-1:0] low_m, high_m, wid_m;
    logic [ST-1:0] step_inc;
    logic [ST-1:0] total;
    logic [ST-1:0] mixed_total;

    assign mode      = hpdpg_pkg::mode_t'(s_tuser[2:0]);
    assign seg_index = s_tdata[4:0];
    assign seg_width = s_tdata[28:5];
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !m_valid_reg || m_tready;

    assign low_m     = low_width_reg[SW-1:0];
    assign high_m    = high_width_reg[SW-1:0];
    assign wid_m     = seg_width[SW-1:0];
    assign idx_wide  = {4'b0, seg_index};
    assign seg_waddr = idx_wide[AW-1:0];
    assign step_inc  = step_reg + ST'(1);

    assign mixed_total = ({3'b0, segment_count_reg} > MAX_9) ? MAX_ST :
                         ST'(segment_count_reg);
    assign total = mixed_mode_reg ? mixed_total : {repeat_count_reg, 1'b0};

    always_comb
    begin
        line_level_next = line_level_reg;
        running_next    = running_reg;
        mixed_mode_next = mixed_mode_reg;
        ticks_left_next = ticks_left_reg;
        step_next       = step_reg;
        seg_we          = 1'b0;
        err             = 1'b0;
        if (accept)
        begin
            if (mode == hpdpg_pkg::MODE_TICK)
            begin
                if (running_reg)
                begin
                    if (ticks_left_reg > SW'(1))
                    begin
                        ticks_left_next = ticks_left_reg - SW'(1);
                    end
                    else if (step_inc >= total)
                    begin
                        // last phase done: drop to idle at the final level
                        running_next    = 1'b0;
                        ticks_left_next = '0;
                        step_next       = step_inc;
                        line_level_next = mixed_mode_reg ? total[0] : end_high_reg;
                    end
                    else
                    begin
                        step_next       = step_inc;
                        line_level_next = step_inc[0];
                        if (mixed_mode_reg)
                        begin
                            ticks_left_next = seg_rdata;
                        end
                        else
                        begin
                            ticks_left_next = step_inc[0] ? high_m : low_m;
                        end
                    end
                end
            end
            else if (running_reg)
            begin
                err = 1'b1;
            end
            else
            begin
                case (mode)
                    hpdpg_pkg::MODE_PLUG:
                    begin
                        line_level_next = 1'b1;
                    end
                    hpdpg_pkg::MODE_UNPLUG:
                    begin
                        line_level_next = 1'b0;
                    end
                    hpdpg_pkg::MODE_LOAD_SEG:
                    begin
                        if ((wid_m == '0) || (idx_wide >= MAX_9))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            seg_we = 1'b1;
                        end
                    end
                    hpdpg_pkg::MODE_START_RP:
                    begin
                        if ((low_m == '0) || (high_m == '0) || (repeat_count_reg == '0))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            mixed_mode_next = 1'b0;
                            running_next    = 1'b1;
                            step_next       = '0;
                            line_level_next = 1'b0;
                            ticks_left_next = low_m;
                        end
                    end
                    hpdpg_pkg::MODE_START_MX:
                    begin
                        if ((segment_count_reg == '0) || ({3'b0, segment_count_reg} > MAX_9))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            // idle read address is slot 0, so its width is already here
                            mixed_mode_next = 1'b1;
                            running_next    = 1'b1;
                            step_next       = '0;
                            line_level_next = 1'b0;
                            ticks_left_next = seg_rdata;
                        end
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase
            end
        end
    end

    // prefetch the width of the phase after the next one
    assign raddr_step = step_next + ST'(1);
    assign seg_raddr  = running_next ? raddr_step[AW-1:0] : '0;

    assign m_valid_next = accept || (m_valid_reg && !m_tready);

    hpdpg_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .DW    (SW)
    ) u_seg_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (seg_we),
        .waddr (seg_waddr),
        .wdata (wid_m),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_width_reg     <= hpdpg_pkg::FIELD_WIDTH'(1);
            high_width_reg    <= hpdpg_pkg::FIELD_WIDTH'(1);
            repeat_count_reg  <= hpdpg_pkg::REPEAT_BITS'(1);
            end_high_reg      <= 1'b1;
            segment_count_reg <= hpdpg_pkg::SEGCNT_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (hpdpg_pkg::cfg_index_t'(cfg_index))
                hpdpg_pkg::CFG_LOW_WIDTH:  low_width_reg     <= cfg_wdata;
                hpdpg_pkg::CFG_HIGH_WIDTH: high_width_reg    <= cfg_wdata;
                hpdpg_pkg::CFG_REPEAT_CNT: repeat_count_reg  <= cfg_wdata[15:0];
                hpdpg_pkg::CFG_END_HIGH:   end_high_reg      <= cfg_wdata[0];
                hpdpg_pkg::CFG_SEG_COUNT:  segment_count_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_level_reg <= 1'b0;
            running_reg    <= 1'b0;
            mixed_mode_reg <= 1'b0;
            ticks_left_reg <= '0;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            line_level_reg <= line_level_next;
            running_reg    <= running_next;
            mixed_mode_reg <= mixed_mode_next;
            ticks_left_reg <= ticks_left_next;
            step_reg       <= step_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_out_reg <= line_level_next;
            busy_out_reg  <= running_next;
            error_out_reg <= err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, error_out_reg, busy_out_reg, level_out_reg};

endmodule

FILE: src/hpdpg_checker.sv
// Port-level checks for the hot-plug-detect pulse pattern generator.
// Depends on hpdpg_pkg; bound to the top level at the end of this file.
module hpdpg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    logic in_xact;
    assign in_xact = s_tvalid && s_tready;

    // hold a result until the receiver takes it
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // every input transaction yields a result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> m_tvalid)
        else $error("no result after input transaction");

    // a tick is never rejected
    a_tick_ok: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact && (s_tuser[2:0] == hpdpg_pkg::MODE_TICK) |=> !m_tdata[2])
        else $error("tick flagged as error");

    // unused kinds are always rejected
    a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact && (s_tuser[2:0] == 3'd6 || s_tuser[2:0] == 3'd7) |=> m_tdata[2])
        else $error("unused item kind accepted");

    // an accepted plug drives the line high unless it is flagged as an error
    a_plug_high: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact && (s_tuser[2:0] == hpdpg_pkg::MODE_PLUG) |=> m_tdata[2] || m_tdata[0])
        else $error("plug did not raise the line");

endmodule

bind hpd_pulse_pattern_generator hpdpg_checker u_hpdpg_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for hpd_pulse_pattern_generator: directed and random items
// go in on the slave stream, and every result is checked against a cycle-free line model.
// Depends on hpdpg_pkg and the RTL of the block.
module tb;

    localparam int SEG_SLOTS = 32;
    localparam int SHORT_WIDTH = 64;   // widths above this are too slow to play
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic level;
        logic busy;
        logic err;
    } hpd_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tuser;      // [2:0] mode
    logic [31:0] s_tdata;      // [4:0] seg_index, [28:5] seg_width
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;      // [0] hpd_level, [1] busy_res, [2] error
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_wdata;

    // line model state and its copy of the registers
    logic        line_level;
    logic        line_running;
    logic        line_mixed;
    logic [23:0] ticks_left;
    logic [16:0] phase_num;
    logic [23:0] seg_width_mem [SEG_SLOTS];
    bit          seg_loaded [SEG_SLOTS];
    bit          seg_slow [SEG_SLOTS];
    logic [23:0] reg_low_w;
    logic [23:0] reg_high_w;
    logic [15:0] reg_repeats;
    logic        reg_end_high;
    logic [5:0]  reg_seg_count;

    hpd_result_t expected_results [$];
    int          errors = 0;
    int          items_sent = 0;
    bit          no_gaps = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    hpd_pulse_pattern_generator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [23:0] phase_len(int unsigned ph);
        if (line_mixed)
            return (ph < SEG_SLOTS) ? seg_width_mem[ph] : 24'd0;
        return ph[0] ? reg_high_w : reg_low_w;
    endfunction

    function automatic void start_sequence(logic mixed);
        line_mixed = mixed;
        line_running = 1'b1;
        phase_num = '0;
        line_level = 1'b0;
        ticks_left = phase_len(0);
    endfunction

    function automatic hpd_result_t hpd_predict(logic [2:0] mode, logic [4:0] idx,
                                                logic [23:0] w);
        hpd_result_t r;
        int unsigned nxt;
        int unsigned total;
        r.err = 1'b0;
        if (mode == hpdpg_pkg::MODE_TICK) begin
            if (line_running) begin
                if (ticks_left > 1) begin
                    ticks_left--;
                end
                else begin
                    nxt = int'(phase_num) + 1;
                    if (line_mixed)
                        total = (reg_seg_count > SEG_SLOTS) ? SEG_SLOTS : reg_seg_count;
                    else
                        total = 2 * int'(reg_repeats);
                    if (nxt >= total) begin
                        line_running = 1'b0;
                        ticks_left = '0;
                        phase_num = nxt[16:0];
                        line_level = line_mixed ? total[0] : reg_end_high;
                    end
                    else begin
                        phase_num = nxt[16:0];
                        line_level = nxt[0];
                        ticks_left = phase_len(nxt);
                    end
                end
            end
        end
        else if (line_running || mode > hpdpg_pkg::MODE_START_MX) begin
            r.err = 1'b1;
        end
        else begin
            case (mode)
                hpdpg_pkg::MODE_PLUG:     line_level = 1'b1;
                hpdpg_pkg::MODE_UNPLUG:   line_level = 1'b0;
                hpdpg_pkg::MODE_LOAD_SEG:
                begin
                    if (w == 0) begin
                        r.err = 1'b1;
                    end
                    else begin
                        seg_width_mem[idx] = w;
                        seg_loaded[idx] = 1'b1;
                        seg_slow[idx] = (w > SHORT_WIDTH);
                    end
                end
                hpdpg_pkg::MODE_START_RP:
                begin
                    if (reg_low_w == 0 || reg_high_w == 0 || reg_repeats == 0)
                        r.err = 1'b1;
                    else
                        start_sequence(1'b0);
                end
                default:
                begin
                    if (reg_seg_count == 0 || reg_seg_count > SEG_SLOTS)
                        r.err = 1'b1;
                    else
                        start_sequence(1'b1);
                end
            endcase
        end
        r.level = line_level;
        r.busy = line_running;
        return r;
    endfunction

    // a mixed start may only read slots that hold a short loaded width
    function automatic bit mixed_safe();
        if (line_running || reg_seg_count == 0 || reg_seg_count > SEG_SLOTS)
            return 1'b1;
        for (int i = 0; i < reg_seg_count; i++)
            if (!seg_loaded[i] || seg_slow[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(logic [2:0] mode, logic [4:0] idx, logic [23:0] w);
        int gap;
        if (!no_gaps && $urandom_range(99) < 3) begin
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= {5'b0, mode};
        s_tdata <= {3'b0, w, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(hpd_predict(mode, idx, w));
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk) s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(hpdpg_pkg::cfg_index_t idx, logic [23:0] val);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk) cfg_we <= 1'b0;
        case (idx)
            hpdpg_pkg::CFG_LOW_WIDTH:  reg_low_w = val;
            hpdpg_pkg::CFG_HIGH_WIDTH: reg_high_w = val;
            hpdpg_pkg::CFG_REPEAT_CNT: reg_repeats = val[15:0];
            hpdpg_pkg::CFG_END_HIGH:   reg_end_high = val[0];
            hpdpg_pkg::CFG_SEG_COUNT:  reg_seg_count = val[5:0];
            default: ;
        endcase
    endtask

    // tick until the running sequence ends, mixing in rejected commands
    task automatic play_out(int noise_pct);
        while (line_running) begin
            if ($urandom_range(99) < noise_pct)
                send_item(3'($urandom_range(1, 7)), 5'($urandom), 24'($urandom));
            else
                send_item(hpdpg_pkg::MODE_TICK, 5'($urandom), 24'($urandom));
        end
        repeat ($urandom_range(0, 2))
            send_item(hpdpg_pkg::MODE_TICK, 5'($urandom), 24'($urandom));
    endtask

    task automatic test_idle_commands();
        send_item(hpdpg_pkg::MODE_TICK, 5'h1f, 24'hffffff);
        send_item(hpdpg_pkg::MODE_PLUG, '0, '0);
        send_item(hpdpg_pkg::MODE_TICK, '0, '0);
        send_item(hpdpg_pkg::MODE_UNPLUG, 5'h1f, 24'hffffff);
        send_item(MODE_UNUSED_6, '0, '0);
        send_item(MODE_UNUSED_7, 5'h1f, 24'hffffff);
    endtask

    // runs on the register defaults: one pulse of one tick each, ending high
    task automatic test_repeat_defaults();
        send_item(hpdpg_pkg::MODE_START_RP, '0, '0);
        send_item(hpdpg_pkg::MODE_TICK, '0, '0);
        send_item(hpdpg_pkg::MODE_PLUG, '0, '0);
        send_item(hpdpg_pkg::MODE_TICK, '0, '0);
        send_item(hpdpg_pkg::MODE_TICK, '0, '0);
    endtask

    task automatic test_segment_loads();
        send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'd3, 24'd0);
        send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'd31, 24'hffffff);
        send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'd0, 24'd1);
        send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'd10, 24'h000001);
    endtask

    task automatic test_repeat_errors();
        write_reg(hpdpg_pkg::CFG_LOW_WIDTH, 24'd0);
        send_item(hpdpg_pkg::MODE_START_RP, '0, '0);
        write_reg(hpdpg_pkg::CFG_LOW_WIDTH, 24'd2);
        write_reg(hpdpg_pkg::CFG_HIGH_WIDTH, 24'd0);
        send_item(hpdpg_pkg::MODE_START_RP, '0, '0);
        write_reg(hpdpg_pkg::CFG_HIGH_WIDTH, 24'd3);
        write_reg(hpdpg_pkg::CFG_REPEAT_CNT, 24'd0);
        send_item(hpdpg_pkg::MODE_START_RP, '0, '0);
        write_reg(hpdpg_pkg::CFG_REPEAT_CNT, 24'd3);
        write_reg(hpdpg_pkg::CFG_END_HIGH, 24'd0);
        send_item(hpdpg_pkg::MODE_START_RP, '0, '0);
        send_item(hpdpg_pkg::MODE_PLUG, '0, '0);
        send_item(hpdpg_pkg::MODE_START_MX, '0, '0);
        play_out(0);
    endtask

    task automatic test_mixed_play();
        write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'd0);
        send_item(hpdpg_pkg::MODE_START_MX, '0, '0);
        write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'd33);
        send_item(hpdpg_pkg::MODE_START_MX, '0, '0);
        write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'd63);
        send_item(hpdpg_pkg::MODE_START_MX, '0, '0);
        for (int i = 0; i < SEG_SLOTS; i++)
            send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'(i), 24'($urandom_range(1, 3)));
        write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'(SEG_SLOTS));
        send_item(hpdpg_pkg::MODE_START_MX, '0, '0);
        play_out(5);
        // odd count ends high, even count ends low
        write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'd3);
        send_item(hpdpg_pkg::MODE_START_MX, '0, '0);
        play_out(0);
        write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'd2);
        send_item(hpdpg_pkg::MODE_PLUG, '0, '0);
        send_item(hpdpg_pkg::MODE_START_MX, '0, '0);
        play_out(0);
    endtask

    // extreme register values, exercised only through commands that stay short
    task automatic test_register_extremes();
        write_reg(hpdpg_pkg::CFG_LOW_WIDTH, 24'hffffff);
        write_reg(hpdpg_pkg::CFG_HIGH_WIDTH, 24'hffffff);
        write_reg(hpdpg_pkg::CFG_REPEAT_CNT, 24'hffffff);
        write_reg(hpdpg_pkg::CFG_END_HIGH, 24'hffffff);
        write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'hffffff);
        send_item(hpdpg_pkg::MODE_START_MX, '0, '0);
        send_item(hpdpg_pkg::MODE_PLUG, '0, '0);
        send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'd5, 24'h555555);
        send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'd6, 24'haaaaaa);
        send_item(hpdpg_pkg::MODE_UNPLUG, '0, '0);
    endtask

    // long repeat run with no idling on either side
    task automatic test_long_repeat();
        write_reg(hpdpg_pkg::CFG_LOW_WIDTH, 24'd1);
        write_reg(hpdpg_pkg::CFG_HIGH_WIDTH, 24'd1);
        write_reg(hpdpg_pkg::CFG_REPEAT_CNT, 24'd60);
        write_reg(hpdpg_pkg::CFG_END_HIGH, 24'd0);
        send_item(hpdpg_pkg::MODE_START_RP, '0, '0);
        no_gaps = 1'b1;
        while (line_running && phase_num < 17'd100)
            send_item(hpdpg_pkg::MODE_TICK, 5'($urandom), 24'($urandom));
        no_gaps = 1'b0;
        play_out(1);
    endtask

    task automatic test_backpressure();
        write_reg(hpdpg_pkg::CFG_REPEAT_CNT, 24'd8);
        write_reg(hpdpg_pkg::CFG_LOW_WIDTH, 24'd2);
        write_reg(hpdpg_pkg::CFG_END_HIGH, 24'd1);
        hold_req = 1'b1;
        send_item(hpdpg_pkg::MODE_START_RP, '0, '0);
        play_out(10);
    endtask

    task automatic random_config();
        write_reg(hpdpg_pkg::CFG_LOW_WIDTH,
                  ($urandom_range(15) == 0) ? 24'd0 : 24'($urandom_range(1, 5)));
        write_reg(hpdpg_pkg::CFG_HIGH_WIDTH,
                  ($urandom_range(15) == 0) ? 24'd0 : 24'($urandom_range(1, 5)));
        write_reg(hpdpg_pkg::CFG_REPEAT_CNT, 24'($urandom_range(0, 5)));
        write_reg(hpdpg_pkg::CFG_END_HIGH, 24'($urandom));
        write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'($urandom_range(0, 40)));
    endtask

    task automatic test_random();
        int stop_at;
        int n;
        logic [2:0] mode;
        logic [23:0] w;
        stop_at = items_sent + 700;
        random_config();
        while (items_sent < stop_at) begin
            play_out(8);
            case ($urandom_range(9))
                0: random_config();
                1, 2, 3:
                begin
                    if ($urandom_range(1))
                        send_item(hpdpg_pkg::MODE_PLUG, '0, '0);
                    send_item(hpdpg_pkg::MODE_START_RP, 5'($urandom), 24'($urandom));
                end
                4, 5, 6:
                begin
                    n = ($urandom_range(3) == 0) ? $urandom_range(1, SEG_SLOTS)
                                                 : $urandom_range(1, 6);
                    write_reg(hpdpg_pkg::CFG_SEG_COUNT, 24'(n));
                    for (int i = 0; i < n; i++) begin
                        if (!seg_loaded[i] || seg_slow[i] || $urandom_range(1)) begin
                            if ($urandom_range(9) == 0)
                                send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'(i), 24'd0);
                            send_item(hpdpg_pkg::MODE_LOAD_SEG, 5'(i),
                                      24'($urandom_range(1, 4)));
                        end
                    end
                    send_item(hpdpg_pkg::MODE_START_MX, 5'($urandom), 24'($urandom));
                end
                default:
                begin
                    repeat ($urandom_range(5, 15)) begin
                        mode = 3'($urandom_range(7));
                        if (mode == hpdpg_pkg::MODE_START_MX && !mixed_safe())
                            mode = hpdpg_pkg::MODE_TICK;
                        w = ($urandom_range(3) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(0, 6));
                        send_item(mode, 5'($urandom), w);
                    end
                end
            endcase
        end
        play_out(8);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 60;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= no_gaps || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge clk)
    begin : check_results
        hpd_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %0h", $time, m_tdata);
                errors++;
            end
            else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.level) begin
                    $display("%0t: hpd_level expected %0b, actual %0b",
                             $time, want.level, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.busy) begin
                    $display("%0t: busy_res expected %0b, actual %0b",
                             $time, want.busy, m_tdata[1]);
                    errors++;
                end
                if (m_tdata[2] !== want.err) begin
                    $display("%0t: error expected %0b, actual %0b",
                             $time, want.err, m_tdata[2]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : main
        int k;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = hpdpg_pkg::CFG_LOW_WIDTH;
        cfg_wdata = '0;
        line_level = 1'b0;
        line_running = 1'b0;
        line_mixed = 1'b0;
        ticks_left = '0;
        phase_num = '0;
        reg_low_w = 24'd1;
        reg_high_w = 24'd1;
        reg_repeats = 16'd1;
        reg_end_high = 1'b1;
        reg_seg_count = 6'd1;
        for (int i = 0; i < SEG_SLOTS; i++) begin
            seg_width_mem[i] = '0;
            seg_loaded[i] = 1'b0;
            seg_slow[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_idle_commands();
        test_repeat_defaults();
        test_segment_loads();
        test_repeat_errors();
        test_mixed_play();
        test_register_extremes();
        test_long_repeat();
        test_backpressure();
        test_random();

        @(negedge clk) s_tvalid <= 1'b0;
        for (k = 0; k < 2000 && expected_results.size() != 0; k++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
